>>> rtl/core/llc_pkg.sv
// Package for the linked list core: sizes, null index, command and status codes,
// and the request structs that the controller sends to the two entry memories.
// Depends on nothing; every other file of the core but llc_ram imports it.
`default_nettype none

package llc_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);

    localparam logic [IDX_W-1:0] NIL = IDX_W'(CAPACITY);

    typedef enum logic [2:0] {
        CMD_INS_FRONT  = 3'd0,
        CMD_INS_BACK   = 3'd1,
        CMD_REM_FRONT  = 3'd2,
        CMD_CUR_START  = 3'd3,
        CMD_ADVANCE    = 3'd4,
        CMD_CUR_INSERT = 3'd5,
        CMD_CUR_REMOVE = 3'd6,
        CMD_CLEAR      = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [IDX_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } t_next_req;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_data_req;

endpackage

`default_nettype wire

>>> rtl/core/linked_list_with_cursor_core.sv
// Linked list with cursor: top level, joining the sequencer to the link and data memories.
// Cursor start, clear and refused commands give their result in the cycle after the
// accepting edge; inserts step through S_ALLOC_WAIT (reused entry only), S_LINK and,
// but at the front or into an empty list, S_LINK2; removes and advance step through
// S_UNLINK_WAIT and S_DATA_WAIT. One command at a time; start is taken again in the cycle the result shows.
// Reset (synchronous, active low) empties the list; no memory clearing pass is needed.
`default_nettype none

module linked_list_with_cursor_core
    import llc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_command,
    input  wire logic [31:0] i_value,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [31:0]      o_removed_value,
    output logic [6:0]       o_length,
    output logic             o_is_empty,
    output logic [31:0]      o_first_value,
    output logic [31:0]      o_last_value,
    output logic [31:0]      o_current_value,
    output logic             o_at_end
);

    // The sequencer keeps the list pointers and cached words in flip-flops and
    // steps through the memories; a transaction finishes with a one-cycle
    // strobe on o_done while the result fields describe the list after it.
    t_next_req         next_req;
    t_data_req         data_req;
    logic [IDX_W-1:0]  next_rdata;
    logic [DATA_W-1:0] data_rdata;

    llc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_value         (i_value),
        .o_next_req      (next_req),
        .i_next_rdata    (next_rdata),
        .o_data_req      (data_req),
        .i_data_rdata    (data_rdata),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_length        (o_length),
        .o_is_empty      (o_is_empty),
        .o_first_value   (o_first_value),
        .o_last_value    (o_last_value),
        .o_current_value (o_current_value),
        .o_at_end        (o_at_end)
    );

    // Link memory: the successor index of every entry, NIL at the tail.
    // Entries of the free chain reuse the same field.
    llc_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (IDX_W)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_req.we),
        .i_waddr (next_req.waddr),
        .i_wdata (next_req.wdata),
        .i_raddr (next_req.raddr),
        .o_rdata (next_rdata)
    );

    // Data memory: the stored word of every entry.
    llc_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_req.we),
        .i_waddr (data_req.waddr),
        .i_wdata (data_req.wdata),
        .i_raddr (data_req.raddr),
        .o_rdata (data_rdata)
    );

endmodule

`default_nettype wire

>>> rtl/core/llc_ram.sv
// Generic single-write, single-read synchronous memory with a registered read port.
// Holds either the entry links or the entry data words; no package dependencies.
`default_nettype none

module llc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/llc_ctrl.sv
// Command sequencer of the linked list core: list pointers, cached end and cursor
// words, free chain, and the read-modify-write steps on the two entry memories.
// Depends on llc_pkg.
`default_nettype none

module llc_ctrl
    import llc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        i_command,
    input  wire logic [31:0]       i_value,
    output t_next_req              o_next_req,
    input  wire logic [IDX_W-1:0]  i_next_rdata,
    output t_data_req              o_data_req,
    input  wire logic [DATA_W-1:0] i_data_rdata,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic [31:0]            o_removed_value,
    output logic [6:0]             o_length,
    output logic                   o_is_empty,
    output logic [31:0]            o_first_value,
    output logic [31:0]            o_last_value,
    output logic [31:0]            o_current_value,
    output logic                   o_at_end
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_WAIT,
        S_LINK,
        S_LINK2,
        S_UNLINK_WAIT,
        S_DATA_WAIT
    } t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    t_status           r_status;
    logic              r_done;
    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] r_removed;

    logic [IDX_W-1:0]  r_head, r_tail, r_cur, r_prev, r_free_head;
    logic [IDX_W-1:0]  r_count, r_fresh;
    logic [DATA_W-1:0] r_head_data, r_tail_data, r_cur_data, r_prev_data;

    logic [IDX_W-1:0]  r_n, r_old, r_aux, r_nx;
    logic              r_front, r_upd_head, r_upd_cur, r_relink;

    logic   accept;
    t_cmd   in_cmd;
    logic   is_insert;
    logic   full;
    logic   ins_front, ins_back;

    assign accept    = start && (r_state == S_IDLE);
    assign in_cmd    = t_cmd'(i_command);
    assign is_insert = (in_cmd == CMD_INS_FRONT) || (in_cmd == CMD_INS_BACK) ||
                       (in_cmd == CMD_CUR_INSERT);
    assign full      = (r_free_head == NIL) && (r_fresh == IDX_W'(CAPACITY));

    // Placement of a new entry, decided from the latched command and pointers.
    assign ins_front = (r_cmd == CMD_INS_FRONT) ||
                       ((r_cmd == CMD_CUR_INSERT) && (r_prev == NIL));
    assign ins_back  = !ins_front && ((r_cmd == CMD_INS_BACK) ||
                       ((r_cmd == CMD_CUR_INSERT) && (r_cur == NIL)));

    always_comb begin
        o_next_req       = '0;
        o_next_req.wdata = NIL;
        o_data_req       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (is_insert) begin
                    o_next_req.raddr = r_free_head[ADDR_W-1:0];
                end else if ((in_cmd == CMD_REM_FRONT) ||
                             ((in_cmd == CMD_CUR_REMOVE) && (r_prev == NIL))) begin
                    o_next_req.raddr = r_head[ADDR_W-1:0];
                end else begin
                    o_next_req.raddr = r_cur[ADDR_W-1:0];
                end
            end
            S_ALLOC_WAIT: begin
            end
            S_LINK: begin
                o_data_req.we    = 1'b1;
                o_data_req.waddr = r_n[ADDR_W-1:0];
                o_data_req.wdata = r_val;
                o_next_req.we    = 1'b1;
                o_next_req.waddr = r_n[ADDR_W-1:0];
                if (ins_front) begin
                    o_next_req.wdata = r_head;
                end else if (ins_back) begin
                    o_next_req.wdata = NIL;
                end else begin
                    o_next_req.wdata = r_cur;
                end
            end
            S_LINK2: begin
                o_next_req.we    = 1'b1;
                o_next_req.waddr = r_aux[ADDR_W-1:0];
                o_next_req.wdata = r_n;
            end
            S_UNLINK_WAIT: begin
                // Unless advancing, push the removed entry onto the free chain; fetch the word
                // of the entry that follows it or the cursor.
                o_next_req.we    = (r_cmd != CMD_ADVANCE);
                o_next_req.waddr = r_old[ADDR_W-1:0];
                o_next_req.wdata = r_free_head;
                o_data_req.raddr = i_next_rdata[ADDR_W-1:0];
            end
            S_DATA_WAIT: begin
                o_next_req.we    = r_relink;
                o_next_req.waddr = r_aux[ADDR_W-1:0];
                o_next_req.wdata = r_nx;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NIL;
            r_tail      <= NIL;
            r_cur       <= NIL;
            r_prev      <= NIL;
            r_free_head <= NIL;
            r_count     <= '0;
            r_fresh     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd      <= in_cmd;
                        r_val      <= i_value[DATA_W-1:0];
                        r_removed  <= '0;
                        r_status   <= ST_OK;
                        r_front    <= 1'b0;
                        r_upd_head <= 1'b0;
                        r_upd_cur  <= 1'b0;
                        r_relink   <= 1'b0;
                        unique case (in_cmd)
                            CMD_INS_FRONT, CMD_INS_BACK, CMD_CUR_INSERT: begin
                                if (full) begin
                                    r_status <= ST_FULL;
                                    r_done   <= 1'b1;
                                end else if (r_free_head != NIL) begin
                                    r_n     <= r_free_head;
                                    r_state <= S_ALLOC_WAIT;
                                end else begin
                                    r_n     <= r_fresh;
                                    r_fresh <= r_fresh + 1'b1;
                                    r_state <= S_LINK;
                                end
                            end
                            CMD_REM_FRONT: begin
                                if (r_count == '0) begin
                                    r_status <= ST_NONE;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_old     <= r_head;
                                    r_removed <= r_head_data;
                                    r_front   <= 1'b1;
                                    r_state   <= S_UNLINK_WAIT;
                                end
                            end
                            CMD_CUR_START: begin
                                r_cur      <= r_head;
                                r_cur_data <= r_head_data;
                                r_prev     <= NIL;
                                r_done     <= 1'b1;
                            end
                            CMD_ADVANCE: begin
                                if (r_cur == NIL) begin
                                    r_status <= ST_NONE;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_prev      <= r_cur;
                                    r_prev_data <= r_cur_data;
                                    r_state     <= S_UNLINK_WAIT;
                                end
                            end
                            CMD_CUR_REMOVE: begin
                                if ((r_count == '0) || (r_cur == NIL)) begin
                                    r_status <= ST_NONE;
                                    r_done   <= 1'b1;
                                end else if (r_prev == NIL) begin
                                    r_old     <= r_head;
                                    r_removed <= r_head_data;
                                    r_front   <= 1'b1;
                                    r_state   <= S_UNLINK_WAIT;
                                end else begin
                                    r_old     <= r_cur;
                                    r_removed <= r_cur_data;
                                    r_aux     <= r_prev;
                                    r_state   <= S_UNLINK_WAIT;
                                end
                            end
                            CMD_CLEAR: begin
                                r_head      <= NIL;
                                r_tail      <= NIL;
                                r_cur       <= NIL;
                                r_prev      <= NIL;
                                r_free_head <= NIL;
                                r_count     <= '0;
                                r_fresh     <= '0;
                                r_done      <= 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_ALLOC_WAIT: begin
                    r_free_head <= i_next_rdata;
                    r_state     <= S_LINK;
                end
                S_LINK: begin
                    r_count <= r_count + 1'b1;
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                    if (ins_front) begin
                        r_head      <= r_n;
                        r_head_data <= r_val;
                        if (r_count == '0) begin
                            r_tail      <= r_n;
                            r_tail_data <= r_val;
                        end
                        if ((r_cmd == CMD_INS_FRONT) && (r_prev == NIL)) begin
                            r_prev      <= r_n;
                            r_prev_data <= r_val;
                        end
                    end else if (ins_back) begin
                        r_tail      <= r_n;
                        r_tail_data <= r_val;
                        if (r_count == '0) begin
                            r_head      <= r_n;
                            r_head_data <= r_val;
                        end else begin
                            r_aux   <= r_tail;
                            r_state <= S_LINK2;
                            r_done  <= 1'b0;
                        end
                        if ((r_cmd == CMD_INS_BACK) && (r_cur == NIL)) begin
                            r_prev      <= r_n;
                            r_prev_data <= r_val;
                        end
                    end else begin
                        r_aux   <= r_prev;
                        r_state <= S_LINK2;
                        r_done  <= 1'b0;
                    end
                    if (r_cmd == CMD_CUR_INSERT) begin
                        r_cur      <= r_n;
                        r_cur_data <= r_val;
                    end
                end
                S_LINK2: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                end
                S_UNLINK_WAIT: begin
                    r_nx    <= i_next_rdata;
                    r_state <= S_DATA_WAIT;
                    if (r_cmd == CMD_ADVANCE) begin
                        r_cur     <= i_next_rdata;
                        r_upd_cur <= 1'b1;
                    end else begin
                        r_free_head <= r_old;
                        r_count     <= r_count - 1'b1;
                        if (r_front) begin
                            r_upd_head <= 1'b1;
                            if (r_count == IDX_W'(1)) begin
                                r_head <= NIL;
                                r_tail <= NIL;
                            end else begin
                                r_head <= i_next_rdata;
                            end
                            if ((r_cmd == CMD_CUR_REMOVE) || (r_cur == r_old)) begin
                                r_cur     <= (r_count == IDX_W'(1)) ? NIL : i_next_rdata;
                                r_prev    <= NIL;
                                r_upd_cur <= 1'b1;
                            end else if (r_prev == r_old) begin
                                r_prev <= NIL;
                            end
                        end else begin
                            r_cur     <= i_next_rdata;
                            r_upd_cur <= 1'b1;
                            r_relink  <= 1'b1;
                            if (r_tail == r_old) begin
                                r_tail      <= r_prev;
                                r_tail_data <= r_prev_data;
                            end
                        end
                    end
                end
                S_DATA_WAIT: begin
                    if (r_upd_head) begin
                        r_head_data <= i_data_rdata;
                    end
                    if (r_upd_cur) begin
                        r_cur_data <= i_data_rdata;
                    end
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_removed_value = 32'(r_removed);
    assign o_length        = 7'(r_count);
    assign o_is_empty      = (r_count == '0);
    assign o_first_value   = (r_count == '0) ? '0 : 32'(r_head_data);
    assign o_last_value    = (r_count == '0) ? '0 : 32'(r_tail_data);
    assign o_current_value = (r_cur == NIL) ? '0 : 32'(r_cur_data);
    assign o_at_end        = (r_cur == NIL);

endmodule

`default_nettype wire

>>> rtl/core/llc_checker.sv
// Port-level checker for the linked list core, bound to the top level.
// Depends on llc_pkg for the capacity.
`default_nettype none

module llc_checker
    import llc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_done,
    input wire logic [6:0]  o_length,
    input wire logic        o_is_empty,
    input wire logic [31:0] o_first_value,
    input wire logic [31:0] o_last_value,
    input wire logic [31:0] o_current_value,
    input wire logic        o_at_end
);

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted transaction neither busy nor done");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_length <= 7'(CAPACITY)) && (o_is_empty == (o_length == 7'd0)))
        else $error("length out of range or empty flag wrong");

    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_is_empty) |-> ((o_first_value == 32'd0) && (o_last_value == 32'd0)
                                    && o_at_end))
        else $error("empty list shows words or a cursor");

    a_end_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_at_end) |-> (o_current_value == 32'd0))
        else $error("cursor at end shows a word");

endmodule

bind linked_list_with_cursor_core llc_checker u_llc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_length        (o_length),
    .o_is_empty      (o_is_empty),
    .o_first_value   (o_first_value),
    .o_last_value    (o_last_value),
    .o_current_value (o_current_value),
    .o_at_end        (o_at_end)
);

`default_nettype wire
